[rtl/bapq_pkg.sv]
// Shared types and constants of the bounded alert priority queue.
`default_nettype none

package bapq_pkg;

	localparam int LEVEL_W  = 3;
	localparam int OPCODE_W = 2;
	localparam int LIMIT_W  = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT      = 2'd0,
		OP_POP_NEWEST  = 2'd1,
		OP_POP_HIGHEST = 2'd2,
		OP_NOP         = 2'd3
	} opcode_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic insert;
		logic read_newest;
		logic pop_newest;
		logic scan_init;
		logic scan_run;
		logic shift_init;
		logic shift_run;
		logic shift_finish;
		logic no_result;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		opcode_t opcode;
		logic    empty;
		logic    walk_done;
	} status_t;

endpackage

`default_nettype wire

[rtl/bounded_alert_priority_queue.sv]
// Bounded alert priority queue: top level joining controller and datapath.
// Insert, no-op and empty pops: the word is latched, decoded, then its result is loaded for output.
// Pop newest: one memory read with registered data.
// Pop highest with n entries held, found at position p: the single read port of the entry
// memory walks the entries once to scan and once more from p on to close the gap.
// One operation at a time; a new word is taken while the last result waits at the output.
// Reset is asynchronous: queue empty, limit 16; entry memory is not cleared.
`default_nettype none

module bounded_alert_priority_queue #(
	parameter int DEPTH         = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [bapq_pkg::LIMIT_W-1:0]     entry_limit,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [bapq_pkg::OPCODE_W-1:0]    opcode,
	input  wire  [bapq_pkg::LEVEL_W-1:0]     in_level,
	input  wire  [PAYLOAD_WIDTH-1:0]         in_payload,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             found,
	output logic [bapq_pkg::LEVEL_W-1:0]     out_level,
	output logic [PAYLOAD_WIDTH-1:0]         out_payload,
	output logic                             evicted,
	output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

	bapq_pkg::cmd_t    cmd;
	bapq_pkg::status_t status;

	assign cfg_ready = 1'b1;

	bapq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bapq_datapath #(
		.DEPTH         (DEPTH),
		.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_write   (cfg_valid && cfg_ready),
		.entry_limit (entry_limit),
		.opcode      (opcode),
		.in_level    (in_level),
		.in_payload  (in_payload),
		.found       (found),
		.out_level   (out_level),
		.out_payload (out_payload),
		.evicted     (evicted),
		.occupancy   (occupancy)
	);

endmodule

`default_nettype wire

[rtl/bapq_datapath.sv]
// Datapath of the alert queue: entry memory, pointers, scan and compaction walk, result registers.
`default_nettype none

module bapq_datapath #(
	parameter int DEPTH         = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  bapq_pkg::cmd_t               cmd,
	output bapq_pkg::status_t                  status,
	input  wire                                cfg_write,
	input  wire  [bapq_pkg::LIMIT_W-1:0]       entry_limit,
	input  wire  [bapq_pkg::OPCODE_W-1:0]      opcode,
	input  wire  [bapq_pkg::LEVEL_W-1:0]       in_level,
	input  wire  [PAYLOAD_WIDTH-1:0]           in_payload,
	output logic                               found,
	output logic [bapq_pkg::LEVEL_W-1:0]       out_level,
	output logic [PAYLOAD_WIDTH-1:0]           out_payload,
	output logic                               evicted,
	output logic [$clog2(DEPTH+1)-1:0]         occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > bapq_pkg::LIMIT_W) ? CW : bapq_pkg::LIMIT_W;
	localparam int LV = bapq_pkg::LEVEL_W;
	localparam int EW = LV + PAYLOAD_WIDTH;
	localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

	// Map a position counted from the oldest entry onto a memory address.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
		logic [AW+1:0] sum;
		sum = (AW+2)'(head) + (AW+2)'(pos);
		if (sum >= (AW+2)'(DEPTH)) begin
			sum = sum - (AW+2)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [EW-1:0]             mem [DEPTH];
	logic [EW-1:0]             rd_q;
	logic [AW-1:0]             rd_addr;
	logic [AW-1:0]             wr_addr;
	logic [EW-1:0]             wr_data;
	logic                      wr_en;

	logic [AW-1:0]             head_q;
	logic [CW-1:0]             count_q;
	logic [bapq_pkg::LIMIT_W-1:0] limit_q;
	bapq_pkg::opcode_t         op_q;
	logic [LV-1:0]             lvl_q;
	logic [PAYLOAD_WIDTH-1:0]  pay_q;

	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             idx_s1;
	logic                      vld_s1;
	logic [LV-1:0]             best_lvl_q;
	logic [CW-1:0]             best_pos_q;
	logic [PAYLOAD_WIDTH-1:0]  best_pay_q;

	logic                      res_found_q;
	logic [LV-1:0]             res_lvl_q;
	logic [PAYLOAD_WIDTH-1:0]  res_pay_q;
	logic                      res_evicted_q;

	logic [LW-1:0]             limit_ext;
	logic [LW-1:0]             eff_limit;
	logic                      evict;
	logic                      issue;
	logic [LV-1:0]             rd_lvl;
	logic [PAYLOAD_WIDTH-1:0]  rd_pay;
	logic [AW-1:0]             head_inc;

	assign rd_lvl = rd_q[EW-1 -: LV];
	assign rd_pay = rd_q[PAYLOAD_WIDTH-1:0];

	always_comb begin
		limit_ext = LW'(limit_q);
		if (limit_ext == '0) begin
			eff_limit = LW'(1);
		end else if (limit_ext > DEPTH_L) begin
			eff_limit = DEPTH_L;
		end else begin
			eff_limit = limit_ext;
		end
	end

	// A limit of at least one makes a full store also a nonempty one.
	assign evict    = LW'(count_q) >= eff_limit;
	assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign issue    = idx_q < count_q;

	assign status.opcode    = op_q;
	assign status.empty     = (count_q == '0);
	assign status.walk_done = (idx_q == count_q) && !vld_s1;

	// Read and write addresses of the entry memory.
	always_comb begin
		if (cmd.read_newest) begin
			rd_addr = phys(head_q, count_q - CW'(1));
		end else begin
			rd_addr = phys(head_q, idx_q);
		end
		wr_en   = 1'b0;
		wr_addr = phys(head_q, idx_s1 - CW'(1));
		wr_data = rd_q;
		if (cmd.insert) begin
			// The new tail goes to the slot after the newest entry, the oldest entry's slot when the store is full.
			wr_en   = 1'b1;
			wr_addr = phys(head_q, count_q);
			wr_data = {lvl_q, pay_q};
		end else if (cmd.shift_run && vld_s1) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			limit_q <= bapq_pkg::LIMIT_RESET;
			op_q    <= bapq_pkg::OP_NOP;
			idx_q   <= '0;
			idx_s1  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_write) begin
				limit_q <= entry_limit;
			end
			if (cmd.latch) begin
				op_q <= bapq_pkg::opcode_t'(opcode);
			end
			if (cmd.insert) begin
				if (evict) begin
					head_q <= head_inc;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.pop_newest || cmd.shift_finish) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_init) begin
				idx_q  <= '0;
				vld_s1 <= 1'b0;
			end else if (cmd.shift_init) begin
				idx_q  <= best_pos_q + CW'(1);
				vld_s1 <= 1'b0;
			end else if (cmd.scan_run || cmd.shift_run) begin
				// Advance the walk: one read issued a cycle, data seen the next.
				if (issue) begin
					idx_q <= idx_q + CW'(1);
				end
				idx_s1 <= idx_q;
				vld_s1 <= issue;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			lvl_q <= in_level;
			pay_q <= in_payload;
		end
		if (cmd.scan_init) begin
			best_lvl_q <= '0;
			best_pos_q <= '0;
		end else if (cmd.scan_run && vld_s1 && (rd_lvl >= best_lvl_q)) begin
			// Later entries win ties, so the one nearest the tail is kept.
			best_lvl_q <= rd_lvl;
			best_pos_q <= idx_s1;
			best_pay_q <= rd_pay;
		end
		if (cmd.insert) begin
			res_found_q   <= 1'b0;
			res_lvl_q     <= '0;
			res_pay_q     <= '0;
			res_evicted_q <= evict;
		end else if (cmd.pop_newest) begin
			res_found_q   <= 1'b1;
			res_lvl_q     <= rd_lvl;
			res_pay_q     <= rd_pay;
			res_evicted_q <= 1'b0;
		end else if (cmd.shift_init) begin
			res_found_q   <= 1'b1;
			res_lvl_q     <= best_lvl_q;
			res_pay_q     <= best_pay_q;
			res_evicted_q <= 1'b0;
		end else if (cmd.no_result) begin
			res_found_q   <= 1'b0;
			res_lvl_q     <= '0;
			res_pay_q     <= '0;
			res_evicted_q <= 1'b0;
		end
		if (cmd.out_load) begin
			found       <= res_found_q;
			out_level   <= res_lvl_q;
			out_payload <= res_pay_q;
			evicted     <= res_evicted_q;
			occupancy   <= count_q;
		end
	end

endmodule

`default_nettype wire

[rtl/bapq_ctrl.sv]
// Controller state machine of the alert queue and the output word's valid flag.
`default_nettype none

module bapq_ctrl (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire                      out_ready,
	input  wire  bapq_pkg::status_t  status,
	output bapq_pkg::cmd_t           cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DECODE = 6'b000010,
		ST_NEWEST = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_SHIFT  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch  = 1'b1;
					state_next = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (status.opcode)
					bapq_pkg::OP_INSERT: begin
						cmd.insert = 1'b1;
						state_next = ST_DONE;
					end
					bapq_pkg::OP_POP_NEWEST: begin
						if (status.empty) begin
							cmd.no_result = 1'b1;
							state_next    = ST_DONE;
						end else begin
							cmd.read_newest = 1'b1;
							state_next      = ST_NEWEST;
						end
					end
					bapq_pkg::OP_POP_HIGHEST: begin
						if (status.empty) begin
							cmd.no_result = 1'b1;
							state_next    = ST_DONE;
						end else begin
							cmd.scan_init = 1'b1;
							state_next    = ST_SCAN;
						end
					end
					bapq_pkg::OP_NOP: begin
						cmd.no_result = 1'b1;
						state_next    = ST_DONE;
					end
					default: begin
						cmd.no_result = 1'b1;
						state_next    = ST_DONE;
					end
				endcase
			end
			ST_NEWEST: begin
				cmd.pop_newest = 1'b1;
				state_next     = ST_DONE;
			end
			ST_SCAN: begin
				if (status.walk_done) begin
					cmd.shift_init = 1'b1;
					state_next     = ST_SHIFT;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			ST_SHIFT: begin
				if (status.walk_done) begin
					cmd.shift_finish = 1'b1;
					state_next       = ST_DONE;
				end else begin
					cmd.shift_run = 1'b1;
				end
			end
			ST_DONE: begin
				// Hold the result until the output register frees up.
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[verif/bounded_alert_priority_queue_tb.sv]
// Self-checking testbench for the bounded alert priority queue.
`timescale 1ns / 100ps

module bounded_alert_priority_queue_tb;

	localparam int DEPTH         = 16;
	localparam int PAYLOAD_WIDTH = 32;
	localparam int LEVEL_W       = bapq_pkg::LEVEL_W;
	localparam int LIMIT_W       = bapq_pkg::LIMIT_W;
	localparam int OCC_W         = $clog2(DEPTH + 1);
	localparam int IDLE_LIMIT    = 3000;
	localparam int HOLD_CYCLES   = 300;
	localparam int TAIL_CYCLES   = 60;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 48;

	typedef struct packed {
		bapq_pkg::opcode_t        op;
		logic [LEVEL_W-1:0]       level;
		logic [PAYLOAD_WIDTH-1:0] payload;
	} alert_cmd_t;

	typedef struct packed {
		logic                     found;
		logic [LEVEL_W-1:0]       level;
		logic [PAYLOAD_WIDTH-1:0] payload;
		logic                     evicted;
		logic [OCC_W-1:0]         occupancy;
	} alert_result_t;

	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     cfg_valid  = 1'b0;
	wire                      cfg_ready;
	logic [LIMIT_W-1:0]       limit_word = bapq_pkg::LIMIT_RESET;
	logic                     in_valid   = 1'b0;
	wire                      in_ready;
	alert_cmd_t               offer      = '{op: bapq_pkg::OP_NOP, level: '0, payload: '0};
	wire                      out_valid;
	logic                     out_ready  = 1'b0;
	wire                      found;
	wire [LEVEL_W-1:0]        out_level;
	wire [PAYLOAD_WIDTH-1:0]  out_payload;
	wire                      evicted;
	wire [OCC_W-1:0]          occupancy;

	// Predicted contents of the store, oldest first.
	logic [LEVEL_W-1:0]       held_level[$];
	logic [PAYLOAD_WIDTH-1:0] held_payload[$];
	logic [LIMIT_W-1:0]       limit_setting = bapq_pkg::LIMIT_RESET;

	alert_cmd_t               pending_cmds[$];
	alert_result_t            result_fifo[$];

	bit in_fire, out_fire, cfg_fire;
	bit stall_request, hold_done;
	int cfg_count, idle_cycles, fail_count, checked_words;
	int n_insert, n_evict, n_pop_hit, n_pop_empty, n_nop, peak_fill;
	int burst_left, gap_left, hold_left, rx_cycle;
	rx_mode_t rx_mode = RX_FREE;

	bounded_alert_priority_queue #(
		.DEPTH(DEPTH),
		.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.entry_limit(limit_word),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(offer.op),
		.in_level(offer.level),
		.in_payload(offer.payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.out_level(out_level),
		.out_payload(out_payload),
		.evicted(evicted),
		.occupancy(occupancy)
	);

	always #5 clk = ~clk;

	// Apply one operation to the predicted store and return the result word it gives.
	function automatic alert_result_t apply_alert_op(alert_cmd_t c);
		alert_result_t r;
		int keep;
		int pos;
		int i;
		r = '0;
		keep = int'(limit_setting);
		if (keep == 0)
			keep = 1;
		else if (keep > DEPTH)
			keep = DEPTH;
		case (c.op)
		bapq_pkg::OP_INSERT: begin
			n_insert++;
			// Drop only one oldest entry, even when the limit was lowered below the count.
			if (held_level.size() >= keep && held_level.size() > 0) begin
				held_level.delete(0);
				held_payload.delete(0);
				r.evicted = 1'b1;
				n_evict++;
			end
			if (held_level.size() < DEPTH) begin
				held_level.insert(held_level.size(), c.level);
				held_payload.insert(held_payload.size(), c.payload);
			end
		end
		bapq_pkg::OP_POP_NEWEST, bapq_pkg::OP_POP_HIGHEST: begin
			if (held_level.size() == 0) begin
				n_pop_empty++;
			end else begin
				pos = held_level.size() - 1;
				if (c.op == bapq_pkg::OP_POP_HIGHEST) begin
					// Ties go to the entry nearest the tail.
					pos = 0;
					for (i = 0; i < held_level.size(); i++)
						if (held_level[i] >= held_level[pos])
							pos = i;
				end
				r.found   = 1'b1;
				r.level   = held_level[pos];
				r.payload = held_payload[pos];
				held_level.delete(pos);
				held_payload.delete(pos);
				n_pop_hit++;
			end
		end
		default: begin
			n_nop++;
		end
		endcase
		r.occupancy = OCC_W'(held_level.size());
		if (held_level.size() > peak_fill)
			peak_fill = held_level.size();
		return r;
	endfunction

	task automatic check_field(string name, logic [PAYLOAD_WIDTH-1:0] want,
			logic [PAYLOAD_WIDTH-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Monitor: predict on each accepted input word, check each accepted result word.
	always @(posedge clk) begin
		alert_result_t want;
		in_fire  = arst_n && in_valid && in_ready;
		out_fire = arst_n && out_valid && out_ready;
		cfg_fire = arst_n && cfg_valid && cfg_ready;
		if (cfg_fire) begin
			limit_setting = limit_word;
			cfg_count++;
		end
		if (in_fire)
			result_fifo.insert(result_fifo.size(), apply_alert_op(offer));
		if (out_fire) begin
			if (result_fifo.size() == 0) begin
				$error("result word with no operation pending");
				fail_count++;
			end else begin
				want = result_fifo[0];
				result_fifo.delete(0);
				checked_words++;
				check_field("found", PAYLOAD_WIDTH'(want.found), PAYLOAD_WIDTH'(found));
				check_field("out_level", PAYLOAD_WIDTH'(want.level), PAYLOAD_WIDTH'(out_level));
				check_field("out_payload", want.payload, out_payload);
				check_field("evicted", PAYLOAD_WIDTH'(want.evicted), PAYLOAD_WIDTH'(evicted));
				check_field("occupancy", PAYLOAD_WIDTH'(want.occupancy),
					PAYLOAD_WIDTH'(occupancy));
			end
		end
		if (!arst_n || in_fire || out_fire || cfg_fire) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("no handshake for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Driver: offer pending words in bursts with random gaps.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				offer = pending_cmds[0];
				pending_cmds.delete(0);
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 16);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: the stall pattern is redrawn at random periodically; one long hold-off on request.
	always @(negedge clk) begin
		rx_cycle++;
		if (stall_request && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (rx_cycle % 64 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
			RX_FREE:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= rx_cycle[2];
			endcase
		end
	end

	task automatic add_cmd(bapq_pkg::opcode_t op, logic [LEVEL_W-1:0] lvl,
			logic [PAYLOAD_WIDTH-1:0] pay);
		pending_cmds.insert(pending_cmds.size(), '{op: op, level: lvl, payload: pay});
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_cmds.size() != 0 || in_valid || result_fifo.size() != 0);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		int seen;
		seen = cfg_count;
		@(negedge clk);
		limit_word = value;
		cfg_valid <= 1'b1;
		while (cfg_count == seen)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int phase_limit[PHASES];
		int insert_pct;
		int top_level;
		int r;
		int p;
		int k;
		phase_limit = '{31, 3, 17, 0, 16, 1, 9, 31, 2, 16};
		phase_limit[6] = $urandom_range(0, 31);
		burst_left = $urandom_range(1, 16);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pops, field extremes, level ties, every opcode.
		add_cmd(bapq_pkg::OP_POP_NEWEST, 0, 0);
		add_cmd(bapq_pkg::OP_POP_HIGHEST, 0, 0);
		add_cmd(bapq_pkg::OP_NOP, 7, 32'hFFFF_FFFF);
		add_cmd(bapq_pkg::OP_INSERT, 0, 32'h0000_0000);
		add_cmd(bapq_pkg::OP_INSERT, 7, 32'hFFFF_FFFF);
		add_cmd(bapq_pkg::OP_INSERT, 3, 32'hA5A5_A5A5);
		add_cmd(bapq_pkg::OP_INSERT, 7, 32'h5A5A_5A5A);
		add_cmd(bapq_pkg::OP_NOP, 0, 0);
		add_cmd(bapq_pkg::OP_POP_HIGHEST, 0, 0);
		add_cmd(bapq_pkg::OP_INSERT, 1, 32'h0000_0001);
		add_cmd(bapq_pkg::OP_POP_NEWEST, 0, 0);
		add_cmd(bapq_pkg::OP_POP_HIGHEST, 0, 0);
		add_cmd(bapq_pkg::OP_POP_HIGHEST, 0, 0);
		add_cmd(bapq_pkg::OP_POP_HIGHEST, 0, 0);
		add_cmd(bapq_pkg::OP_POP_NEWEST, 0, 0);
		wait_idle();
		write_limit(1);
		add_cmd(bapq_pkg::OP_INSERT, 5, 32'h8000_0000);
		add_cmd(bapq_pkg::OP_INSERT, 2, 32'h7FFF_FFFF);
		add_cmd(bapq_pkg::OP_POP_NEWEST, 0, 0);
		wait_idle();
		write_limit(0);
		add_cmd(bapq_pkg::OP_INSERT, 6, 32'h1234_5678);
		add_cmd(bapq_pkg::OP_INSERT, 4, 32'h8765_4321);
		add_cmd(bapq_pkg::OP_POP_HIGHEST, 0, 0);

		// Random phases: alternate filling and draining, narrow levels now and then for ties.
		for (p = 0; p < PHASES; p++) begin
			wait_idle();
			write_limit(LIMIT_W'(phase_limit[p]));
			if (p == 0)
				stall_request = 1'b1;
			insert_pct = (p % 2 == 0) ? 75 : 45;
			top_level  = (p % 3 == 0) ? 1 : 7;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < insert_pct) begin
					add_cmd(bapq_pkg::OP_INSERT, LEVEL_W'($urandom_range(0, top_level)),
						$urandom());
				end else begin
					r = $urandom_range(0, 9);
					if (r == 0)
						add_cmd(bapq_pkg::OP_NOP, LEVEL_W'($urandom_range(0, 7)),
							$urandom());
					else if (r < 5)
						add_cmd(bapq_pkg::OP_POP_NEWEST, LEVEL_W'($urandom_range(0, 7)),
							$urandom());
					else
						add_cmd(bapq_pkg::OP_POP_HIGHEST, LEVEL_W'($urandom_range(0, 7)),
							$urandom());
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("ran %0d inserts (%0d evicting), %0d pops returning an entry, %0d on empty,",
			n_insert, n_evict, n_pop_hit, n_pop_empty);
		$display("%0d no-ops, %0d limit writes, peak fill %0d, %0d result words checked",
			n_nop, cfg_count, peak_fill, checked_words);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
